[sv/lfs_pkg.sv]
`timescale 1ns / 1ps

package lfs_pkg;

    // default table shape
    localparam int SLOT_COUNT_DEF    = 512;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // slots searched together by the first level of the free-slot encoder
    localparam int GROUP_W = 64;

    // operation codes
    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_IN_USE = 2'd2
    } t_status;

endpackage

[sv/lfs_pick.sv]
`timescale 1ns / 1ps

// lowest free slot of the used map, two-level search: group, then bit in group
module lfs_pick #(
    parameter int SLOT_COUNT = lfs_pkg::SLOT_COUNT_DEF
) (
    input  logic [SLOT_COUNT-1:0]         i_used,
    output logic                          o_found,
    output logic [$clog2(SLOT_COUNT)-1:0] o_index
);

    localparam int GROUP_W = lfs_pkg::GROUP_W;
    localparam int NG      = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W   = NG * GROUP_W;
    localparam int GB      = (NG > 1) ? $clog2(NG) : 1;
    localparam int BB      = $clog2(GROUP_W);
    localparam int IW      = $clog2(SLOT_COUNT);

    logic [PAD_W-1:0]   free_pad;
    logic [GROUP_W-1:0] word [NG];
    logic [NG-1:0]      grp_free;
    logic [NG-1:0]      grp_oh;
    logic [GB-1:0]      grp_idx;
    logic [GROUP_W-1:0] sel_word;
    logic [GROUP_W-1:0] bit_oh;
    logic [BB-1:0]      bit_idx;
    logic [GB+BB-1:0]   full_idx;

    // free map, padding slots count as used
    for (genvar i = 0; i < PAD_W; i++) begin : g_pad
        if (i < SLOT_COUNT) begin : g_real
            assign free_pad[i] = ~i_used[i];
        end else begin : g_fill
            assign free_pad[i] = 1'b0;
        end
    end

    // split into groups, one free flag per group
    for (genvar g = 0; g < NG; g++) begin : g_grp
        assign word[g]     = free_pad[g*GROUP_W +: GROUP_W];
        assign grp_free[g] = |word[g];
    end

    // lowest group with a free slot, as one-hot and as index
    assign grp_oh = grp_free & (~grp_free + NG'(1));

    always_comb begin
        grp_idx  = '0;
        sel_word = '0;
        for (int g = 0; g < NG; g++) begin
            if (grp_oh[g]) begin
                grp_idx  = grp_idx | GB'(g);
                sel_word = sel_word | word[g];
            end
        end
    end

    // lowest free bit inside the chosen group
    assign bit_oh = sel_word & (~sel_word + GROUP_W'(1));

    always_comb begin
        bit_idx = '0;
        for (int i = 0; i < GROUP_W; i++) begin
            if (bit_oh[i]) begin
                bit_idx = bit_idx | BB'(i);
            end
        end
    end

    assign full_idx = {grp_idx, bit_idx};
    assign o_found  = |grp_free;
    assign o_index  = full_idx[IW-1:0];

endmodule

[sv/lowest_free_slot_handle_table.sv]
`timescale 1ns / 1ps

// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------------
// in       | i_in_valid / o_in_ready   | i_operation, i_element_value, i_slot_index
// out      | o_out_valid / i_out_ready | o_granted_index, o_freed_element, o_status
//
// one item per cycle sustained unless the output stalls; each item is held first in
// the input register, then in the result register, with the free-slot encoder and
// used map update between them; the element store read lands with the result
// reset clears the used map at once (every slot free); the element store is not cleared
// a stalled output holds one result, and one more item waits in the input register

module lowest_free_slot_handle_table #(
    parameter int SLOT_COUNT    = lfs_pkg::SLOT_COUNT_DEF,
    parameter int ELEMENT_WIDTH = lfs_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [ELEMENT_WIDTH-1:0]      i_element_value,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_slot_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [$clog2(SLOT_COUNT)-1:0] o_granted_index,
    output logic [ELEMENT_WIDTH-1:0]      o_freed_element,
    output logic [1:0]                    o_status
);

    localparam int IW = $clog2(SLOT_COUNT);

    // input register
    logic                     r_s1_valid;
    lfs_pkg::t_op             r_s1_op;
    logic [ELEMENT_WIDTH-1:0] r_s1_elem;
    logic [IW-1:0]            r_s1_idx;

    // table state
    logic [SLOT_COUNT-1:0]    r_used;
    logic [SLOT_COUNT-1:0]    n_used;
    logic [ELEMENT_WIDTH-1:0] r_store [SLOT_COUNT];
    logic [ELEMENT_WIDTH-1:0] r_rd_data;

    // result register
    logic                     r_out_valid;
    logic [IW-1:0]            r_out_grant;
    lfs_pkg::t_status         r_out_status;
    logic                     r_out_freed;

    logic                     in_beat;
    logic                     advance;
    logic                     found;
    logic [IW-1:0]            pick_idx;
    logic                     in_range;
    logic                     rm_ok;
    logic                     add_ok;
    lfs_pkg::t_status         n_status;
    logic [IW-1:0]            n_grant;

    // handshake: input register moves whenever the result register is free
    assign advance     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || advance;
    assign in_beat     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // free-slot search over the used map
    lfs_pick #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_pick (
        .i_used  (r_used),
        .o_found (found),
        .o_index (pick_idx)
    );

    // decision for the item in the input register
    assign in_range = {1'b0, r_s1_idx} < (IW+1)'(SLOT_COUNT);
    assign add_ok   = (r_s1_op == lfs_pkg::OP_ADD) && found;
    assign rm_ok    = (r_s1_op == lfs_pkg::OP_REMOVE) && in_range && r_used[r_s1_idx];

    always_comb begin
        n_grant = '0;
        if (r_s1_op == lfs_pkg::OP_ADD) begin
            n_status = found ? lfs_pkg::ST_OK : lfs_pkg::ST_FULL;
            if (found) begin
                n_grant = pick_idx;
            end
        end else begin
            n_status = rm_ok ? lfs_pkg::ST_OK : lfs_pkg::ST_NOT_IN_USE;
        end
    end

    // used map update
    always_comb begin
        n_used = r_used;
        if (advance && add_ok) begin
            n_used[pick_idx] = 1'b1;
        end
        if (advance && rm_ok) begin
            n_used[r_s1_idx] = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_used      <= '0;
        end else begin
            r_used <= n_used;
            if (in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_op   <= lfs_pkg::t_op'(i_operation);
            r_s1_elem <= i_element_value;
            r_s1_idx  <= i_slot_index;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_grant  <= n_grant;
            r_out_status <= n_status;
            r_out_freed  <= rm_ok;
        end
    end

    // element store: write on add, registered read on remove
    always_ff @(posedge i_clk) begin
        if (advance && add_ok) begin
            r_store[pick_idx] <= r_s1_elem;
        end
        if (advance && rm_ok) begin
            r_rd_data <= r_store[r_s1_idx];
        end
    end

    // outputs
    assign o_granted_index = r_out_grant;
    assign o_freed_element = r_out_freed ? r_rd_data : '0;
    assign o_status        = r_out_status;

    // a granted slot is marked used in the next cycle
    a_add_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && add_ok |=> r_used[$past(pick_idx)])
        else $error("granted slot not marked used");

    // a successful remove frees the slot
    a_rm_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && rm_ok |=> !r_used[$past(r_s1_idx)])
        else $error("removed slot still marked used");

    // full is reported only when every slot is used
    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_s1_op == lfs_pkg::OP_ADD) && !found |-> &r_used)
        else $error("table full reported with a free slot");

    // input stalls only behind a held result and a waiting item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without cause");

endmodule
